@@ hw/rtl/wavp_pkg.sv @@
// Shared types, codes and lookup functions for the WAV header parser.
`timescale 1ns / 1ps

package wavp_pkg;

  typedef enum logic [1:0] {
    STAGE_HEADER = 2'd0,
    STAGE_DATA   = 2'd1,
    STAGE_TRAIL  = 2'd2
  } stage_e;

  typedef enum logic [1:0] {
    KIND_FIELD = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  localparam logic [3:0] FID_FILE_SIZE = 4'd0;
  localparam logic [3:0] FID_FMT_SIZE  = 4'd1;
  localparam logic [3:0] FID_FORMAT    = 4'd2;
  localparam logic [3:0] FID_CHANNELS  = 4'd3;
  localparam logic [3:0] FID_RATE      = 4'd4;
  localparam logic [3:0] FID_BYTE_RATE = 4'd5;
  localparam logic [3:0] FID_ALIGN     = 4'd6;
  localparam logic [3:0] FID_BITS      = 4'd7;
  localparam logic [3:0] FID_DATA_SIZE = 4'd8;

  localparam logic [3:0] TAG_RIFF = 4'd0;
  localparam logic [3:0] TAG_WAVE = 4'd1;
  localparam logic [3:0] TAG_FMT  = 4'd2;
  localparam logic [3:0] TAG_DATA = 4'd3;

  localparam logic [3:0] ERR_HDR_TRUNC  = 4'd4;
  localparam logic [3:0] ERR_FMT_SIZE   = 4'd5;
  localparam logic [3:0] ERR_FORMAT     = 4'd6;
  localparam logic [3:0] ERR_CHANNELS   = 4'd7;
  localparam logic [3:0] ERR_BITS       = 4'd8;
  localparam logic [3:0] ERR_ALIGN      = 4'd9;
  localparam logic [3:0] ERR_BYTE_RATE  = 4'd10;
  localparam logic [3:0] ERR_DATA_TRUNC = 4'd11;
  localparam logic [3:0] ERR_SIZE       = 4'd12;

  localparam logic [31:0] FMT_CHUNK_LEN = 32'd16;
  localparam logic [31:0] FORMAT_PCM    = 32'd1;
  localparam logic [32:0] RIFF_OVERHEAD = 33'd36;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } wav_in_t;

  typedef struct packed {
    kind_e       report_kind;
    logic [3:0]  field_id;
    logic [31:0] field_value;
    logic [3:0]  error_code;
    logic        last_in_run;
  } wav_res_t;

  // Results of one accepted beat, handed to the result queue
  typedef struct packed {
    logic [1:0] cnt;
    wav_res_t   r0;
    wav_res_t   r1;
  } wavp_push_t;

  typedef struct packed {
    logic       is_tag;
    logic [3:0] id;
    logic [1:0] k;
    logic       last;
  } seg_t;

  function automatic seg_t seg_lookup(logic [5:0] pos);
    seg_t s;
    s.is_tag = 1'b0;
    s.k      = pos[1:0];
    s.last   = (pos[1:0] == 2'd3);
    if (pos < 6'd4) begin
      s.is_tag = 1'b1; s.id = TAG_RIFF;
    end else if (pos < 6'd8) begin
      s.id = FID_FILE_SIZE;
    end else if (pos < 6'd12) begin
      s.is_tag = 1'b1; s.id = TAG_WAVE;
    end else if (pos < 6'd16) begin
      s.is_tag = 1'b1; s.id = TAG_FMT;
    end else if (pos < 6'd20) begin
      s.id = FID_FMT_SIZE;
    end else if (pos < 6'd24) begin
      s.id = (pos < 6'd22) ? FID_FORMAT : FID_CHANNELS;
    end else if (pos < 6'd28) begin
      s.id = FID_RATE;
    end else if (pos < 6'd32) begin
      s.id = FID_BYTE_RATE;
    end else if (pos < 6'd36) begin
      s.id = (pos < 6'd34) ? FID_ALIGN : FID_BITS;
    end else if (pos < 6'd40) begin
      s.is_tag = 1'b1; s.id = TAG_DATA;
    end else begin
      s.id = FID_DATA_SIZE;
    end
    // two-byte fields start on even positions
    if (!s.is_tag && (pos >= 6'd20) && (pos < 6'd24 || (pos >= 6'd32 && pos < 6'd36))) begin
      s.k    = {1'b0, pos[0]};
      s.last = pos[0];
    end
    return s;
  endfunction

  function automatic logic [7:0] tag_byte(logic [1:0] tag, logic [1:0] k);
    logic [7:0] b;
    case ({tag, k})
      4'h0: b = 8'h52;
      4'h1: b = 8'h49;
      4'h2: b = 8'h46;
      4'h3: b = 8'h46;
      4'h4: b = 8'h57;
      4'h5: b = 8'h41;
      4'h6: b = 8'h56;
      4'h7: b = 8'h45;
      4'h8: b = 8'h66;
      4'h9: b = 8'h6D;
      4'hA: b = 8'h74;
      4'hB: b = 8'h20;
      4'hC: b = 8'h64;
      4'hD: b = 8'h61;
      4'hE: b = 8'h74;
      4'hF: b = 8'h61;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic wav_res_t mk_field(logic [3:0] id, logic [31:0] val);
    wav_res_t r;
    r.report_kind = KIND_FIELD;
    r.field_id    = id;
    r.field_value = val;
    r.error_code  = 4'd0;
    r.last_in_run = 1'b0;
    return r;
  endfunction

  function automatic wav_res_t mk_error(logic [3:0] code);
    wav_res_t r;
    r.report_kind = KIND_ERROR;
    r.field_id    = 4'd0;
    r.field_value = 32'd0;
    r.error_code  = code;
    r.last_in_run = 1'b0;
    return r;
  endfunction

  function automatic wav_res_t mk_done();
    wav_res_t r;
    r.report_kind = KIND_DONE;
    r.field_id    = 4'd0;
    r.field_value = 32'd0;
    r.error_code  = 4'd0;
    r.last_in_run = 1'b0;
    return r;
  endfunction

endpackage

@@ hw/rtl/wavp_core.sv @@
// Parser state and per-beat result logic of the WAV header parser.
`timescale 1ns / 1ps

module wavp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  wavp_pkg::wav_in_t   in_i,
  output wavp_pkg::wavp_push_t push_o
);

  wavp_pkg::stage_e stage_q, stage_d;
  logic [5:0]  pos_q, pos_d;
  logic        halted_q, halted_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] file_size_q, file_size_d;
  logic [1:0]  chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [31:0] brate_q, brate_d;
  logic [15:0] align_q, align_d;
  logic [31:0] prod_q, prod_d;
  logic [31:0] left_q, left_d;
  logic        overrun_q, overrun_d;

  wavp_pkg::seg_t seg;
  logic [7:0]  b;
  logic        end_beat, is_byte, hdr_byte, tag_bad, fld_done, data_beat, data_fin;
  logic [31:0] shift_new, left_dec;
  logic        overrun_now;
  logic        chk_err;
  logic [3:0]  chk_code;
  logic [2:0]  align_exp;
  logic [47:0] prod_full;
  logic [3:0]  end_code;

  assign seg       = wavp_pkg::seg_lookup(pos_q);
  assign b         = in_i.data_byte;
  assign end_beat  = accept_i && in_i.stream_end && !halted_q;
  assign is_byte   = accept_i && !in_i.stream_end && !halted_q;
  assign hdr_byte  = is_byte && (stage_q == wavp_pkg::STAGE_HEADER);
  assign tag_bad   = hdr_byte && seg.is_tag && (b != wavp_pkg::tag_byte(seg.id[1:0], seg.k));
  assign fld_done  = hdr_byte && !seg.is_tag && seg.last;
  assign shift_new = ((seg.k == 2'd0) ? 32'd0 : shift_q) | ({24'd0, b} << {seg.k, 3'b000});
  assign data_beat = is_byte && (stage_q == wavp_pkg::STAGE_DATA);
  assign left_dec  = (left_q != 32'd0) ? left_q - 32'd1 : 32'd0;
  assign data_fin  = data_beat && (left_dec == 32'd0);
  assign overrun_now = ({1'b0, shift_new} + wavp_pkg::RIFF_OVERHEAD) > {1'b0, file_size_q};
  assign align_exp = (shift_new == 32'd16) ? {chan_q, 1'b0} : {1'b0, chan_q};
  assign prod_full = rate_q * shift_new[15:0];

  // field checks on the value that completes this beat
  always_comb begin
    chk_err  = 1'b0;
    chk_code = wavp_pkg::ERR_FMT_SIZE;
    case (seg.id)
      wavp_pkg::FID_FMT_SIZE: begin
        chk_err = (shift_new != wavp_pkg::FMT_CHUNK_LEN);
      end
      wavp_pkg::FID_FORMAT: begin
        chk_err  = (shift_new != wavp_pkg::FORMAT_PCM);
        chk_code = wavp_pkg::ERR_FORMAT;
      end
      wavp_pkg::FID_CHANNELS: begin
        chk_err  = (shift_new != 32'd1) && (shift_new != 32'd2);
        chk_code = wavp_pkg::ERR_CHANNELS;
      end
      wavp_pkg::FID_BITS: begin
        if ((shift_new != 32'd8) && (shift_new != 32'd16)) begin
          chk_err  = 1'b1;
          chk_code = wavp_pkg::ERR_BITS;
        end else if (align_q != {13'd0, align_exp}) begin
          chk_err  = 1'b1;
          chk_code = wavp_pkg::ERR_ALIGN;
        end else if (brate_q != prod_q) begin
          chk_err  = 1'b1;
          chk_code = wavp_pkg::ERR_BYTE_RATE;
        end
      end
      wavp_pkg::FID_DATA_SIZE: begin
        chk_err  = (shift_new == 32'd0) && overrun_now;
        chk_code = wavp_pkg::ERR_SIZE;
      end
      default: begin
        chk_err = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (stage_q)
      wavp_pkg::STAGE_HEADER:
        end_code = seg.is_tag ? seg.id : wavp_pkg::ERR_HDR_TRUNC;
      wavp_pkg::STAGE_DATA: end_code = wavp_pkg::ERR_DATA_TRUNC;
      default:              end_code = wavp_pkg::ERR_DATA_TRUNC;
    endcase
  end

  // next state
  always_comb begin
    stage_d     = stage_q;
    pos_d       = pos_q;
    halted_d    = halted_q;
    shift_d     = shift_q;
    file_size_d = file_size_q;
    chan_d      = chan_q;
    rate_d      = rate_q;
    brate_d     = brate_q;
    align_d     = align_q;
    prod_d      = prod_q;
    left_d      = left_q;
    overrun_d   = overrun_q;
    if (accept_i && in_i.stream_end) begin
      stage_d  = wavp_pkg::STAGE_HEADER;
      pos_d    = 6'd0;
      halted_d = 1'b0;
    end else if (hdr_byte) begin
      if (tag_bad) begin
        halted_d = 1'b1;
      end else begin
        pos_d = pos_q + 6'd1;
        if (!seg.is_tag) begin
          shift_d = shift_new;
        end
        if (fld_done) begin
          halted_d = chk_err;
          case (seg.id)
            wavp_pkg::FID_FILE_SIZE: file_size_d = shift_new;
            wavp_pkg::FID_CHANNELS:  chan_d = shift_new[1:0];
            wavp_pkg::FID_RATE:      rate_d = shift_new;
            wavp_pkg::FID_BYTE_RATE: brate_d = shift_new;
            wavp_pkg::FID_ALIGN: begin
              align_d = shift_new[15:0];
              prod_d  = prod_full[31:0];
            end
            wavp_pkg::FID_DATA_SIZE: begin
              left_d    = shift_new;
              overrun_d = overrun_now;
              stage_d   = (shift_new == 32'd0) ? wavp_pkg::STAGE_TRAIL : wavp_pkg::STAGE_DATA;
            end
            default: begin
              stage_d = stage_q;
            end
          endcase
        end
      end
    end else if (data_beat) begin
      left_d = left_dec;
      if (data_fin) begin
        if (overrun_q) begin
          halted_d = 1'b1;
        end else begin
          stage_d = wavp_pkg::STAGE_TRAIL;
        end
      end
    end
  end

  // results of this beat
  always_comb begin
    push_o    = '0;
    push_o.r0 = wavp_pkg::mk_done();
    push_o.r1 = wavp_pkg::mk_done();
    if (end_beat) begin
      push_o.cnt = 2'd1;
      if (stage_q == wavp_pkg::STAGE_HEADER ||
          (stage_q == wavp_pkg::STAGE_DATA && left_q != 32'd0)) begin
        push_o.r0 = wavp_pkg::mk_error(end_code);
      end
    end else if (tag_bad) begin
      push_o.cnt = 2'd1;
      push_o.r0  = wavp_pkg::mk_error(seg.id);
    end else if (fld_done) begin
      push_o.r0 = wavp_pkg::mk_field(seg.id, shift_new);
      if (chk_err) begin
        push_o.cnt = 2'd2;
        push_o.r1  = wavp_pkg::mk_error(chk_code);
      end else begin
        push_o.cnt = 2'd1;
      end
    end else if (data_fin && overrun_q) begin
      push_o.cnt = 2'd1;
      push_o.r0  = wavp_pkg::mk_error(wavp_pkg::ERR_SIZE);
    end
    // mark the final result of the run
    push_o.r0.last_in_run = (push_o.cnt == 2'd1);
    push_o.r1.last_in_run = (push_o.cnt == 2'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q  <= wavp_pkg::STAGE_HEADER;
      pos_q    <= 6'd0;
      halted_q <= 1'b0;
    end else begin
      stage_q  <= stage_d;
      pos_q    <= pos_d;
      halted_q <= halted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q     <= shift_d;
    file_size_q <= file_size_d;
    chan_q      <= chan_d;
    rate_q      <= rate_d;
    brate_q     <= brate_d;
    align_q     <= align_d;
    prod_q      <= prod_d;
    left_q      <= left_d;
    overrun_q   <= overrun_d;
  end

endmodule

@@ hw/rtl/wavp_res_fifo.sv @@
// Result queue: takes up to two results per cycle, hands out one per beat.
`timescale 1ns / 1ps

module wavp_res_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wavp_pkg::wavp_push_t push_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wavp_pkg::wav_res_t   out_data_o
);

  localparam int unsigned PtrW = wavp_pkg::QPtrW;
  localparam int unsigned CntW = wavp_pkg::QCntW;

  wavp_pkg::wav_res_t mem_q [wavp_pkg::QDepth];
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d, tail_nxt;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[head_q];
  // hold input while fewer than two slots are free
  assign room_o      = (cnt_q <= CntW'(wavp_pkg::QDepth - 2));
  assign tail_nxt    = tail_q + PtrW'(1);

  always_comb begin
    head_d = pop ? head_q + PtrW'(1) : head_q;
    tail_d = tail_q + PtrW'(push_i.cnt);
    cnt_d  = cnt_q + CntW'(push_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[tail_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[tail_nxt] <= push_i.r1;
    end
  end

endmodule

@@ hw/rtl/wav_header_parser.sv @@
// Top level of the streaming RIFF/WAVE PCM header parser.
`timescale 1ns / 1ps

// Takes one stream byte (or an end-of-stream marker) per beat and reports
// each header field as its last byte arrives, followed in the same run by
// any check error, then counts off the sample bytes and skips the tail.
// A beat is accepted every cycle while the four-entry result queue has at
// least two free slots; its results are registered into the queue and
// handed out one per output beat. A beat that yields two results (a field
// and its error) thus fills two queue slots, and the input stalls only
// once the queue backs up. The first error halts parsing until an
// end-of-stream beat rearms the block.

module wav_header_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wavp_pkg::wav_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wavp_pkg::wav_res_t out_data_o
);

  logic                 accept;
  wavp_pkg::wavp_push_t push;

  assign accept = in_valid_i && in_ready_o;

  wavp_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .in_i    (in_data_i),
    .push_o  (push)
  );

  wavp_res_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // a two-result run is always a field report followed by its error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.cnt == 2'd2 |-> push.r0.report_kind == wavp_pkg::KIND_FIELD &&
                         push.r1.report_kind == wavp_pkg::KIND_ERROR)
    else $error("two-result run is not field then error");

  // an error or finish report always closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.report_kind != wavp_pkg::KIND_FIELD
      |-> out_data_o.last_in_run)
    else $error("error or finish report not last in run");

  // nothing is queued on a beat that was not accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> push.cnt == 2'd0)
    else $error("results pushed without an accepted beat");

endmodule
